FILE: src/abl_pkg.sv
// Package for the audio block level meter: word types, widths, register
// indexes and the sample magnitude helper. No dependencies.
`default_nettype none

package abl_pkg;

    localparam int MAX_BLOCK_FRAMES_DEF = 256;

    localparam int SAMPLE_W    = 8;
    localparam int BAR_W       = 12;
    localparam int FRAME_CNT_W = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int SCALE_SHIFT = 7;     // full scale magnitude is 128
    localparam int BAR_RESET   = 100;

    localparam logic [SAMPLE_W-1:0]  MAG_BIAS    = 8'h80;
    localparam logic [CFG_IDX_W-1:0] REG_STEREO  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BAR_WID = 2'd1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_byte;
        logic                block_end;
    } t_in_word;

    typedef struct packed {
        logic [BAR_W-1:0]       left_level;
        logic [BAR_W-1:0]       left_peak;
        logic [BAR_W-1:0]       right_level;
        logic [BAR_W-1:0]       right_peak;
        logic [FRAME_CNT_W-1:0] frame_count;
    } t_out_word;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] reg_index;
        logic [BAR_W-1:0]     wdata;
    } t_cfg_word;

    // block status handed from the accumulator to the sequencer
    typedef struct packed {
        logic last_byte;
        logic has_frames;
        logic stereo;
    } t_blk_status;

    function automatic logic [SAMPLE_W-1:0] sample_mag(input logic [SAMPLE_W-1:0] b);
        logic [SAMPLE_W-1:0] m;
        if (b >= MAG_BIAS) begin
            m = b - MAG_BIAS;
        end else begin
            m = MAG_BIAS - b;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: src/abl_if.sv
// Valid/ready channel interfaces for the level meter: sample input,
// result output and register write. Depends on abl_pkg.
`default_nettype none

interface abl_in_if;
    import abl_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface abl_out_if;
    import abl_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface abl_cfg_if;
    import abl_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: src/abl_accum.sv
// Per-byte accumulation: stereo pairing, magnitude sums, peaks and frame count.
// Depends on abl_pkg.
`default_nettype none

module abl_accum import abl_pkg::*; #(
    parameter int MAX_BLOCK_FRAMES = MAX_BLOCK_FRAMES_DEF,
    parameter int SUM_W            = $clog2(MAX_BLOCK_FRAMES * 128 + 1),
    parameter int FRM_W            = $clog2(MAX_BLOCK_FRAMES + 1)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_accept,
    input  wire logic [SAMPLE_W-1:0] i_sample,
    input  wire logic                i_last,
    input  wire logic                i_stereo,
    output logic [SUM_W-1:0]         o_sum_l,
    output logic [SUM_W-1:0]         o_sum_r,
    output logic [SAMPLE_W-1:0]      o_max_l,
    output logic [SAMPLE_W-1:0]      o_max_r,
    output logic [FRM_W-1:0]         o_frames,
    output t_blk_status              o_status
);

    logic [SUM_W-1:0]    r_sum_l, r_sum_r, n_sum_l, n_sum_r;
    logic [SAMPLE_W-1:0] r_max_l, r_max_r, n_max_l, n_max_r;
    logic [FRM_W-1:0]    r_frames, n_frames;
    logic [SAMPLE_W-1:0] r_pend, n_pend;
    logic                r_have, n_have;
    logic                r_odd;
    logic                r_at_start;

    logic                skip;
    logic                room;
    logic [SAMPLE_W-1:0] mag_l, mag_r;

    assign skip  = i_stereo && r_at_start && r_odd;
    assign room  = r_frames < FRM_W'(MAX_BLOCK_FRAMES);
    // left byte comes from the pending slot in stereo, from this byte in mono
    assign mag_l = sample_mag(i_stereo ? r_pend : i_sample);
    assign mag_r = sample_mag(i_sample);

    always_comb begin
        n_sum_l  = r_sum_l;
        n_sum_r  = r_sum_r;
        n_max_l  = r_max_l;
        n_max_r  = r_max_r;
        n_frames = r_frames;
        n_pend   = r_pend;
        n_have   = r_have;
        if (!skip) begin
            if (i_stereo && !r_have) begin
                n_have = 1'b1;
                n_pend = i_sample;
            end else begin
                n_have = 1'b0;
                if (room) begin
                    n_sum_l  = r_sum_l + SUM_W'(mag_l);
                    n_max_l  = (mag_l > r_max_l) ? mag_l : r_max_l;
                    n_frames = r_frames + FRM_W'(1);
                    if (i_stereo) begin
                        n_sum_r = r_sum_r + SUM_W'(mag_r);
                        n_max_r = (mag_r > r_max_r) ? mag_r : r_max_r;
                    end
                end
            end
        end
    end

    assign o_sum_l             = n_sum_l;
    assign o_sum_r             = n_sum_r;
    assign o_max_l             = n_max_l;
    assign o_max_r             = n_max_r;
    assign o_frames            = n_frames;
    assign o_status.last_byte  = i_last;
    assign o_status.has_frames = (n_frames != '0);
    assign o_status.stereo     = i_stereo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_l    <= '0;
            r_sum_r    <= '0;
            r_max_l    <= '0;
            r_max_r    <= '0;
            r_frames   <= '0;
            r_have     <= 1'b0;
            r_odd      <= 1'b0;
            r_at_start <= 1'b1;
        end else if (i_accept) begin
            if (i_last) begin
                r_sum_l    <= '0;
                r_sum_r    <= '0;
                r_max_l    <= '0;
                r_max_r    <= '0;
                r_frames   <= '0;
                r_have     <= 1'b0;
                r_odd      <= i_stereo && n_have;
                r_at_start <= 1'b1;
            end else begin
                r_sum_l    <= n_sum_l;
                r_sum_r    <= n_sum_r;
                r_max_l    <= n_max_l;
                r_max_r    <= n_max_r;
                r_frames   <= n_frames;
                r_have     <= n_have;
                r_at_start <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_pend <= n_pend;
        end
    end

endmodule

`default_nettype wire

FILE: src/abl_div.sv
// Restoring divider, one quotient bit per cycle, shared by both level bars.
// Does not depend on abl_pkg.
`default_nettype none

module abl_div #(
    parameter int DVD_W = 22,
    parameter int DVS_W = 9
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DVD_W-1:0] i_dividend,
    input  wire logic [DVS_W-1:0] i_divisor,
    output logic                  o_busy,
    output logic                  o_done,
    output logic [DVD_W-1:0]      o_quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   diff;
    logic             fits;

    // bring down the next dividend bit and try the subtract
    assign shifted = {r_rem, r_quo[DVD_W-1]};
    assign diff    = shifted - {1'b0, r_dvs};
    assign fits    = shifted >= {1'b0, r_dvs};

    assign o_busy     = (r_cnt != '0);
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CNT_W'(DVD_W);
            r_done <= 1'b0;
        end else if (o_busy) begin
            r_cnt  <= r_cnt - CNT_W'(1);
            r_done <= (r_cnt == CNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (o_busy) begin
            r_quo <= {r_quo[DVD_W-2:0], fits};
            r_rem <= fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
        end
    end

endmodule

`default_nettype wire

FILE: src/audio_block_level_meter_unit.sv
// Level meter top: config registers, accumulator, bar-length sequencer with
// one shared multiplier and one shared divider, result register.
// Bar math: a block-end byte that closes a non-empty block is followed by the peak steps and
//   a multiply and divide for the left level, then in stereo for the right level, before the
//   result word shows; the bit-serial divider works on DVD_W = SUM_W+6 bits (22 at 256 frames).
// Throughput: one byte per cycle inside a block; input held off during the bar math.
// Reset: synchronous active low; clears block state, mono mode, bar width 100.
`default_nettype none

module audio_block_level_meter_unit import abl_pkg::*; #(
    parameter int MAX_BLOCK_FRAMES = MAX_BLOCK_FRAMES_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    abl_in_if.sink      i_in,
    abl_out_if.source   o_out,
    abl_cfg_if.sink     i_cfg
);

    localparam int SUM_W  = $clog2(MAX_BLOCK_FRAMES * 128 + 1);
    localparam int FRM_W  = $clog2(MAX_BLOCK_FRAMES + 1);
    localparam int PROD_W = SUM_W + BAR_W + 1;
    localparam int DVD_W  = PROD_W - SCALE_SHIFT;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PK_L  = 3'd1;
    localparam logic [2:0] ST_PK_R  = 3'd2;
    localparam logic [2:0] ST_MUL_L = 3'd3;
    localparam logic [2:0] ST_DIV_L = 3'd4;
    localparam logic [2:0] ST_MUL_R = 3'd5;
    localparam logic [2:0] ST_DIV_R = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    logic             r_stereo_mode;
    logic [BAR_W-1:0] r_bar_width;

    logic [2:0]          r_state;
    logic [SUM_W-1:0]    r_sum_l, r_sum_r;
    logic [SAMPLE_W-1:0] r_max_l, r_max_r;
    logic [FRM_W-1:0]    r_frames;
    logic                r_stereo;
    logic [BAR_W-1:0]    r_lpk, r_rpk, r_llv, r_rlv;
    logic                r_out_valid;
    t_out_word           r_out_data;

    logic                in_accept;
    logic [SUM_W-1:0]    acc_sum_l, acc_sum_r;
    logic [SAMPLE_W-1:0] acc_max_l, acc_max_r;
    logic [FRM_W-1:0]    acc_frames;
    t_blk_status         acc_status;

    logic [SUM_W-1:0]  mul_a;
    logic [PROD_W-1:0] addend;
    logic [PROD_W-1:0] prod;
    logic [DVD_W-1:0]  prod_sh;
    logic              div_start, div_busy, div_done;
    logic [DVD_W-1:0]  div_quo;
    logic              out_free;

    // ---------------- configuration ----------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stereo_mode <= 1'b0;
            r_bar_width   <= BAR_W'(BAR_RESET);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.reg_index)
                REG_STEREO:  r_stereo_mode <= i_cfg.data.wdata[0];
                REG_BAR_WID: r_bar_width   <= i_cfg.data.wdata;
                default: ;
            endcase
        end
    end

    // ---------------- accumulation ----------------
    assign i_in.ready = (r_state == ST_IDLE);
    assign in_accept  = i_in.valid && i_in.ready;

    abl_accum #(
        .MAX_BLOCK_FRAMES (MAX_BLOCK_FRAMES),
        .SUM_W            (SUM_W),
        .FRM_W            (FRM_W)
    ) u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_sample (i_in.data.sample_byte),
        .i_last   (i_in.data.block_end),
        .i_stereo (r_stereo_mode),
        .o_sum_l  (acc_sum_l),
        .o_sum_r  (acc_sum_r),
        .o_max_l  (acc_max_l),
        .o_max_r  (acc_max_r),
        .o_frames (acc_frames),
        .o_status (acc_status)
    );

    // ---------------- shared multiplier ----------------
    // peaks: (max*W + 64) >> 7; levels: (sum*W + frames*64) >> 7, then / frames
    always_comb begin
        mul_a  = '0;
        addend = PROD_W'(1) << (SCALE_SHIFT - 1);
        unique case (r_state)
            ST_PK_L:  mul_a = SUM_W'(r_max_l);
            ST_PK_R:  mul_a = SUM_W'(r_max_r);
            ST_MUL_L: begin
                mul_a  = r_sum_l;
                addend = PROD_W'(r_frames) << (SCALE_SHIFT - 1);
            end
            ST_MUL_R: begin
                mul_a  = r_sum_r;
                addend = PROD_W'(r_frames) << (SCALE_SHIFT - 1);
            end
            default: ;
        endcase
    end

    assign prod    = PROD_W'(mul_a) * PROD_W'(r_bar_width) + addend;
    assign prod_sh = prod[PROD_W-1:SCALE_SHIFT];

    assign div_start = (r_state == ST_MUL_L) || (r_state == ST_MUL_R);

    abl_div #(
        .DVD_W (DVD_W),
        .DVS_W (FRM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (prod_sh),
        .i_divisor  (r_frames),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // ---------------- sequencer ----------------
    assign out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_accept && acc_status.last_byte && acc_status.has_frames) begin
                        r_state <= ST_PK_L;
                    end
                end
                ST_PK_L:  r_state <= ST_PK_R;
                ST_PK_R:  r_state <= ST_MUL_L;
                ST_MUL_L: r_state <= ST_DIV_L;
                ST_DIV_L: begin
                    if (div_done) begin
                        r_state <= r_stereo ? ST_MUL_R : ST_OUT;
                    end
                end
                ST_MUL_R: r_state <= ST_DIV_R;
                ST_DIV_R: begin
                    if (div_done) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // snapshot of the finished block and bar results
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    r_sum_l  <= acc_sum_l;
                    r_sum_r  <= acc_sum_r;
                    r_max_l  <= acc_max_l;
                    r_max_r  <= acc_max_r;
                    r_frames <= acc_frames;
                    r_stereo <= acc_status.stereo;
                end
            end
            ST_PK_L: r_lpk <= prod_sh[BAR_W-1:0];
            ST_PK_R: r_rpk <= r_stereo ? prod_sh[BAR_W-1:0] : '0;
            ST_DIV_L: begin
                if (div_done) begin
                    r_llv <= div_quo[BAR_W-1:0];
                    r_rlv <= '0;
                end
            end
            ST_DIV_R: begin
                if (div_done) begin
                    r_rlv <= div_quo[BAR_W-1:0];
                end
            end
            default: ;
        endcase
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && out_free) begin
            r_out_data.left_level  <= r_llv;
            r_out_data.left_peak   <= r_lpk;
            r_out_data.right_level <= r_rlv;
            r_out_data.right_peak  <= r_rpk;
            r_out_data.frame_count <= FRAME_CNT_W'(r_frames);
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    // ---------------- assertions ----------------
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_OUT)
        else $error("result word raised outside the output step");

    a_mono_right_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) && !r_stereo |-> (r_rlv == '0) && (r_rpk == '0))
        else $error("right bars nonzero for a mono block");

    a_frames_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_frames != '0))
        else $error("bar math running on an empty block");

endmodule

`default_nettype wire

FILE: sim/tb_audio_block_level_meter_unit.sv
// Testbench for audio_block_level_meter_unit: drives sample words and register
// writes, predicts the per-block bar lengths and checks every result word.
// Depends on abl_pkg, abl_if and the meter RTL.
`timescale 1ns / 100ps

module tb_audio_block_level_meter_unit;
    import abl_pkg::*;

    localparam logic [SAMPLE_W-1:0] SILENCE     = 8'h80;
    localparam int                  TOTAL_ITEMS = 1550;
    localparam int                  DRAIN_CYCLES = 100;   // covers the stereo divider pass
    localparam int                  LONG_HOLD    = 400;

    // Predicts the bar lengths of each block and holds the words still owed.
    class level_scoreboard;
        logic                   stereo_on;
        logic [BAR_W-1:0]       bar_len;
        logic [15:0]            sum_l, sum_r;
        logic [SAMPLE_W-1:0]    peak_l, peak_r;
        logic [FRAME_CNT_W-1:0] frames;
        logic [SAMPLE_W-1:0]    held_left;
        logic                   left_waiting;
        logic                   carry_odd;
        logic                   block_start;
        t_out_word              owed_q[$];
        int                     errors;

        function new();
            stereo_on = 1'b0;
            bar_len   = BAR_W'(BAR_RESET);
            carry_odd = 1'b0;
            errors    = 0;
            clear_block();
        endfunction

        function void clear_block();
            sum_l = '0;
            sum_r = '0;
            peak_l = '0;
            peak_r = '0;
            frames = '0;
            held_left = '0;
            left_waiting = 1'b0;
            block_start = 1'b1;
        endfunction

        function logic [SAMPLE_W-1:0] magnitude_of(logic [SAMPLE_W-1:0] b);
            return (b >= SILENCE) ? b - SILENCE : SILENCE - b;
        endfunction

        // round(num * bar_len / den), halves up, kept to the bar width
        function logic [BAR_W-1:0] scale_bar(longint unsigned num, longint unsigned den);
            longint unsigned p;
            if (den == 0) begin
                return '0;
            end
            p = num * longint'(bar_len) + den / 2;
            return BAR_W'(p / den);
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [BAR_W-1:0] val);
            if (idx == REG_STEREO) begin
                stereo_on = val[0];
            end else if (idx == REG_BAR_WID) begin
                bar_len = val;
            end
        endfunction

        function void add_frame(logic [SAMPLE_W-1:0] lb, logic [SAMPLE_W-1:0] rb, logic both);
            logic [SAMPLE_W-1:0] ml, mr;
            ml = magnitude_of(lb);
            mr = magnitude_of(rb);
            if (frames >= MAX_BLOCK_FRAMES_DEF) begin
                return;
            end
            if (ml > peak_l) begin
                peak_l = ml;
            end
            sum_l = sum_l + ml;
            if (both) begin
                if (mr > peak_r) begin
                    peak_r = mr;
                end
                sum_r = sum_r + mr;
            end
            frames = frames + 1'b1;
        endfunction

        function void note_input(t_in_word w);
            logic      is_st;
            logic      drop;
            t_out_word r;
            longint unsigned den;
            is_st = stereo_on;
            drop = is_st && block_start && carry_odd;
            block_start = 1'b0;
            if (!drop) begin
                if (is_st) begin
                    if (!left_waiting) begin
                        left_waiting = 1'b1;
                        held_left = w.sample_byte;
                    end else begin
                        left_waiting = 1'b0;
                        add_frame(held_left, w.sample_byte, 1'b1);
                    end
                end else begin
                    // a mono byte discards any half frame
                    left_waiting = 1'b0;
                    add_frame(w.sample_byte, SILENCE, 1'b0);
                end
            end
            if (w.block_end) begin
                carry_odd = is_st && left_waiting;
                if (frames != 0) begin
                    den = longint'(frames) * 128;
                    r.left_level  = scale_bar(sum_l, den);
                    r.left_peak   = scale_bar(peak_l, 128);
                    r.right_level = is_st ? scale_bar(sum_r, den) : '0;
                    r.right_peak  = is_st ? scale_bar(peak_r, 128) : '0;
                    r.frame_count = frames;
                    owed_q.push_back(r);
                end
                clear_block();
            end
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(t_out_word got);
            t_out_word want;
            string     diffs;
            if (owed_q.size() == 0) begin
                report_mismatch("result word with nothing owed");
                return;
            end
            want = owed_q.pop_front();
            diffs = "";
            if (got.left_level !== want.left_level)
                diffs = {diffs, $sformatf(" left_level %0d/%0d", got.left_level, want.left_level)};
            if (got.left_peak !== want.left_peak)
                diffs = {diffs, $sformatf(" left_peak %0d/%0d", got.left_peak, want.left_peak)};
            if (got.right_level !== want.right_level)
                diffs = {diffs, $sformatf(" right_level %0d/%0d", got.right_level,
                                          want.right_level)};
            if (got.right_peak !== want.right_peak)
                diffs = {diffs, $sformatf(" right_peak %0d/%0d", got.right_peak, want.right_peak)};
            if (got.frame_count !== want.frame_count)
                diffs = {diffs, $sformatf(" frame_count %0d/%0d", got.frame_count,
                                          want.frame_count)};
            if (diffs != "") begin
                report_mismatch({"got/want:", diffs});
            end
        endtask

        function int owed();
            return owed_q.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    abl_in_if  in_ch();
    abl_out_if out_ch();
    abl_cfg_if cfg_ch();

    audio_block_level_meter_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    level_scoreboard meter;
    int   idle_pct  = 0;
    int   stall_pct = 0;
    int   hold_req  = 0;
    int   items_sent = 0;
    logic cur_stereo = 1'b0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    // result side: check accepted words, stall at random, honor long hold-offs
    initial begin : result_sink
        int hold_done;
        int hold_left;
        hold_done = 0;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready) begin
                meter.check_result(out_ch.data);
            end
            if (hold_req != hold_done) begin
                hold_left = LONG_HOLD;
                hold_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_byte(input logic [SAMPLE_W-1:0] b, input logic last);
        t_in_word w;
        w.sample_byte = b;
        w.block_end = last;
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.data <= w;
        in_ch.valid <= 1'b1;
        do @(posedge clk); while (!in_ch.ready);
        meter.note_input(w);
        items_sent++;
    endtask

    // hold the sample stream until every owed word is out, then write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BAR_W-1:0] val);
        t_cfg_word c;
        c.reg_index = idx;
        c.wdata = val;
        in_ch.valid <= 1'b0;
        while (meter.owed() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_ch.data <= c;
        cfg_ch.valid <= 1'b1;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        meter.note_config(idx, val);
        if (idx == REG_STEREO) begin
            cur_stereo = val[0];
        end
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_byte();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hFF;
            2: return SILENCE;
            3: return SAMPLE_W'($urandom_range(120, 136));
            default: return SAMPLE_W'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [BAR_W-1:0] pick_width();
        case ($urandom_range(5))
            0: return '0;
            1: return 12'hFFF;
            2: return 12'd1;
            3: return BAR_W'(BAR_RESET);
            default: return BAR_W'($urandom_range(4095));
        endcase
    endfunction

    // mode bit in bit 0, junk above it
    function automatic logic [BAR_W-1:0] pick_mode_word();
        return {11'($urandom_range(2047)), 1'($urandom_range(1))};
    endfunction

    task automatic send_random_block();
        int nfr;
        int nbytes;
        nfr = ($urandom_range(9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 8);
        if (cur_stereo) begin
            nbytes = 2 * nfr + ($urandom_range(4) == 0);
            // a lone byte now and then: empty block, sets the odd carry unless it is itself skipped
            if ($urandom_range(19) == 0) begin
                nbytes = 1;
            end
        end else begin
            nbytes = nfr;
        end
        for (int i = 0; i < nbytes; i++) begin
            if (i > 0 && $urandom_range(99) < 2) begin
                write_reg(REG_STEREO, pick_mode_word());
            end
            send_byte(pick_byte(), i == nbytes - 1);
        end
    endtask

    initial begin : stimulus
        int base;
        int phase_end;
        meter = new();
        rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.data <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: mono, bar width 100; extremes and silence
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(SILENCE, 1'b1);
        send_byte(8'h7F, 1'b1);

        // stereo at full bar width
        write_reg(REG_STEREO, 12'd1);
        write_reg(REG_BAR_WID, 12'hFFF);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(SILENCE, 1'b0);
        send_byte(8'h81, 1'b1);
        send_byte(8'h01, 1'b1);     // lone byte: no frame, odd carry set
        send_byte(8'h55, 1'b0);     // skipped first byte
        send_byte(8'h10, 1'b0);
        send_byte(8'h20, 1'b1);
        send_byte(8'h33, 1'b0);
        send_byte(8'h44, 1'b0);
        send_byte(8'h66, 1'b1);     // ends on a half frame
        send_byte(8'h99, 1'b1);     // skipped and last: nothing counted

        write_reg(REG_BAR_WID, 12'd0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);

        // mode flips inside a block, both ways
        write_reg(REG_BAR_WID, 12'd1);
        send_byte(8'hAA, 1'b0);
        write_reg(REG_STEREO, 12'd0);
        send_byte(8'hBB, 1'b0);
        send_byte(8'hCC, 1'b1);
        send_byte(8'h12, 1'b0);
        write_reg(REG_STEREO, 12'd1);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b1);

        base = items_sent;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 85; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 85; end
                default: begin idle_pct = 11; stall_pct = 11; end
            endcase
            phase_end = base + (ph + 1) * (TOTAL_ITEMS - base) / 4;
            write_reg(REG_BAR_WID, pick_width());
            if (ph == 0) begin
                // full-scale mono block past the frame cap, with the result side held off
                write_reg(REG_STEREO, 12'd0);
                hold_req++;
                for (int i = 0; i < 260; i++) begin
                    send_byte(8'h00, i == 259);
                end
                // a second short block backs up behind the held result word
                send_byte(8'hFF, 1'b0);
                send_byte(8'h00, 1'b1);
            end else if (ph == 1) begin
                write_reg(REG_STEREO, 12'd1);
                for (int i = 0; i < 515; i++) begin
                    send_byte(pick_byte(), i == 514);
                end
            end else begin
                write_reg(REG_STEREO, pick_mode_word());
            end
            while (items_sent < phase_end) begin
                if ($urandom_range(99) < 8) begin
                    if ($urandom_range(1) == 0) begin
                        write_reg(REG_STEREO, pick_mode_word());
                    end else begin
                        write_reg(REG_BAR_WID, pick_width());
                    end
                end
                send_random_block();
            end
        end

        in_ch.valid <= 1'b0;
        while (meter.owed() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (meter.errors == 0 && meter.owed() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
